@@ rtl/core/wsd_pkg.sv @@
// Shared types and constants for the window settling detector.
`default_nettype none
package wsd_pkg;

  localparam int RUN_BITS         = 16;
  localparam int LEN_BITS         = 7;
  localparam int LIMIT_BITS       = 24;
  localparam int SAMPLE_PORT_BITS = 24;
  localparam int CFG_IDX_BITS     = 1;
  localparam int CFG_DATA_BITS    = 24;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEV_LIMIT  = 1'b1;

  // CELL_FWD moves data toward the tail, CELL_BACK toward the head
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FWD,
    CELL_BACK
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     load;
  } chain_ctl_t;

  typedef struct packed {
    logic clear;
    logic accumulate;
    logic test;
  } dev_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/wsd_cell.sv @@
// One storage cell of the sample ring: holds a sample, or takes a neighbor's.
`default_nettype none
module wsd_cell import wsd_pkg::*; #(
  parameter int W = 24
) (
  input  wire logic         clk,
  input  wire cell_op_t     op,
  input  wire logic [W-1:0] prev_d,
  input  wire logic [W-1:0] next_d,
  output logic      [W-1:0] q
);

  logic [W-1:0] data_r;

  always_ff @(posedge clk) begin
    case (op)
      CELL_FWD:  data_r <= prev_d;
      CELL_BACK: data_r <= next_d;
      default:   data_r <= data_r;
    endcase
  end

  assign q = data_r;

endmodule
`default_nettype wire

@@ rtl/core/wsd_chain.sv @@
// Ring of sample cells; the newest sample enters at the head.
`default_nettype none
module wsd_chain import wsd_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int W     = 24
) (
  input  wire logic         clk,
  input  wire chain_ctl_t   ctl,
  input  wire logic [W-1:0] new_d,
  output logic      [W-1:0] head,
  output logic      [W-1:0] tail
);

  logic [W-1:0] cell_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [W-1:0] prev_d;
    logic [W-1:0] next_d;

    if (k == 0) begin : g_first
      // on load the new sample enters; otherwise close the ring
      assign prev_d = ctl.load ? new_d : cell_q[DEPTH-1];
    end else begin : g_mid
      assign prev_d = cell_q[k-1];
    end

    if (k == DEPTH-1) begin : g_last
      assign next_d = cell_q[0];
    end else begin : g_inner
      assign next_d = cell_q[k+1];
    end

    wsd_cell #(.W(W)) u_cell (
      .clk    (clk),
      .op     (ctl.op),
      .prev_d (prev_d),
      .next_d (next_d),
      .q      (cell_q[k])
    );
  end

  assign head = cell_q[0];
  assign tail = cell_q[DEPTH-1];

endmodule
`default_nettype wire

@@ rtl/core/wsd_dev.sv @@
// Window sum accumulator and per-sample deviation test.
`default_nettype none
module wsd_dev import wsd_pkg::*; #(
  parameter int W  = 24,
  parameter int LW = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dev_ctl_t              ctl,
  input  wire logic [LW-1:0]         n,
  input  wire logic [LIMIT_BITS-1:0] limit,
  input  wire logic [W-1:0]          head,
  input  wire logic [W-1:0]          tail,
  output logic                       fail
);

  localparam int DW = ((W > LIMIT_BITS) ? W : LIMIT_BITS) + LW;

  logic [DW-1:0]            sum_r;
  logic [DW-1:0]            bound_r;
  logic [DW-1:0]            prod_r;
  logic                     pv_r;
  logic [LW+LIMIT_BITS-1:0] bound_full;
  logic [LW+W-1:0]          prod_full;
  logic [DW-1:0]            gap;

  assign bound_full = n * limit;
  assign prod_full  = n * tail;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r   <= '0;
      bound_r <= DW'(bound_full);
    end else if (ctl.accumulate) begin
      sum_r <= sum_r + DW'(head);
    end
    if (ctl.test) begin
      prod_r <= DW'(prod_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.test;
    end
  end

  assign gap  = (prod_r > sum_r) ? (prod_r - sum_r) : (sum_r - prod_r);
  assign fail = pv_r && (gap > bound_r);

endmodule
`default_nettype wire

@@ rtl/core/window_settling_detector.sv @@
// Top level of the window settling detector: control sequencer, run state, ports.
// Sequence: an accepted item that runs no check goes straight to ST_DONE, which
//   registers the result. A checking item (n = effective window length, 1..MAX_WINDOW)
//   sums the ring in ST_SUM, tests each sample in ST_TEST, drains in ST_DRAIN, then registers.
// Input is taken only in ST_IDLE, so a new item waits until the last one is
//   through; a stalled result holds the next one in ST_DONE.
// Reset (rst_n, synchronous, active low): clears control and run state, restores default settings.
`default_nettype none
module window_settling_detector import wsd_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // sample input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [SAMPLE_PORT_BITS-1:0] in_entropy_sample,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_converged,
  output logic                             out_check_done,
  output logic [RUN_BITS-1:0]              out_converged_at_run,
  output logic [RUN_BITS-1:0]              out_blocking_run,
  // configuration write port
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

  // LW holds a window length 0..MAX_WINDOW; SEXT covers port and sample widths
  localparam int LW   = $clog2(MAX_WINDOW + 1);
  localparam int SEXT = (SAMPLE_BITS > SAMPLE_PORT_BITS) ? SAMPLE_BITS : SAMPLE_PORT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TEST,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                state_r;
  logic [LEN_BITS-1:0]   win_len_r;
  logic [LIMIT_BITS-1:0] dev_limit_r;
  logic [RUN_BITS-1:0]   run_r;
  logic [RUN_BITS-1:0]   blocker_r;
  logic                  settled_r;
  logic [RUN_BITS-1:0]   settled_run_r;
  logic [LW-1:0]         n_r;
  logic [RUN_BITS-1:0]   base_r;
  logic [LW-1:0]         cnt_r;
  logic [LW-1:0]         tidx_r;
  logic                  found_r;
  logic                  checked_r;

  logic                  out_valid_r;
  logic                  out_conv_r;
  logic                  out_chk_r;
  logic [RUN_BITS-1:0]   out_conv_run_r;
  logic [RUN_BITS-1:0]   out_block_r;

  logic [31:0]           len_ext;
  logic [LW-1:0]         n_eff;
  logic [RUN_BITS-1:0]   n_run;
  logic [RUN_BITS-1:0]   run_nxt;
  logic                  chk;
  logic                  accept;
  logic                  cnt_last;
  logic [SEXT-1:0]       sample_ext;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] ring_head;
  logic [SAMPLE_BITS-1:0] ring_tail;
  chain_ctl_t            chain_ctl;
  dev_ctl_t              dev_ctl;
  logic [LW-1:0]         dev_n;
  logic                  dev_fail;

  // Only the low SAMPLE_BITS bits of a sample take part.
  assign sample_ext = SEXT'(in_entropy_sample);
  assign sample     = sample_ext[SAMPLE_BITS-1:0];

  // Effective window: zero acts as one, anything above the ring depth as the depth.
  assign len_ext = 32'(win_len_r);
  always_comb begin
    if (len_ext == 32'd0) begin
      n_eff = LW'(1);
    end else if (len_ext > 32'(MAX_WINDOW)) begin
      n_eff = LW'(MAX_WINDOW);
    end else begin
      n_eff = LW'(len_ext);
    end
  end
  assign n_run = RUN_BITS'(n_eff);

  // The run counter saturates; once full, run indices stay relative to its top.
  assign run_nxt = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;

  // Check only while unsettled, with a full window, and with the last blocking
  // run older than the window.
  assign chk = !settled_r && (run_nxt >= n_run) && (blocker_r <= (run_nxt - n_run));

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt_last = (cnt_r == (n_r - LW'(1)));

  // Ring movement: a new item shifts in toward the tail. The sum pass rotates
  // toward the head, reading the head newest first; the test pass rotates back
  // toward the tail, reading the tail oldest first, and leaves the ring in place.
  always_comb begin
    chain_ctl.op   = CELL_HOLD;
    chain_ctl.load = 1'b0;
    dev_ctl.clear      = accept;
    dev_ctl.accumulate = (state_r == ST_SUM);
    dev_ctl.test       = (state_r == ST_TEST);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          chain_ctl.op   = CELL_FWD;
          chain_ctl.load = 1'b1;
        end
      end
      ST_SUM:  chain_ctl.op = CELL_BACK;
      ST_TEST: chain_ctl.op = CELL_FWD;
      default: chain_ctl.op = CELL_HOLD;
    endcase
  end

  // The bound is taken in the accept cycle, before n_r is loaded.
  assign dev_n = (state_r == ST_IDLE) ? n_eff : n_r;

  wsd_chain #(
    .DEPTH (MAX_WINDOW),
    .W     (SAMPLE_BITS)
  ) u_chain (
    .clk   (clk),
    .ctl   (chain_ctl),
    .new_d (sample),
    .head  (ring_head),
    .tail  (ring_tail)
  );

  wsd_dev #(
    .W  (SAMPLE_BITS),
    .LW (LW)
  ) u_dev (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dev_ctl),
    .n     (dev_n),
    .limit (dev_limit_r),
    .head  (ring_head),
    .tail  (ring_tail),
    .fail  (dev_fail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      win_len_r     <= LEN_BITS'(25);
      dev_limit_r   <= LIMIT_BITS'(655);
      run_r         <= '0;
      blocker_r     <= '0;
      settled_r     <= 1'b0;
      settled_run_r <= '0;
      n_r           <= '0;
      base_r        <= '0;
      cnt_r         <= '0;
      tidx_r        <= '0;
      found_r       <= 1'b0;
      checked_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // Settings must change only while the block is idle; the block itself does not enforce it.
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LEN: win_len_r   <= cfg_data[LEN_BITS-1:0];
          CFG_DEV_LIMIT:  dev_limit_r <= cfg_data[LIMIT_BITS-1:0];
          default:        win_len_r   <= win_len_r;
        endcase
      end

      // Drop the result once the consumer has taken it; ST_DONE reloads it itself.
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // Record only the first failing sample of a check, oldest first.
      if (dev_fail && !found_r) begin
        found_r   <= 1'b1;
        blocker_r <= base_r + RUN_BITS'(tidx_r);
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            run_r     <= run_nxt;
            n_r       <= n_eff;
            base_r    <= run_nxt - n_run;
            cnt_r     <= '0;
            found_r   <= 1'b0;
            checked_r <= chk;
            state_r   <= chk ? ST_SUM : ST_DONE;
          end
        end
        ST_SUM: begin
          if (cnt_last) begin
            cnt_r   <= '0;
            state_r <= ST_TEST;
          end else begin
            cnt_r <= cnt_r + LW'(1);
          end
        end
        ST_TEST: begin
          tidx_r <= cnt_r;
          if (cnt_last) begin
            state_r <= ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + LW'(1);
          end
        end
        ST_DRAIN: begin
          // Last test result is in; no failure means the window has settled.
          if (!found_r && !dev_fail) begin
            settled_r     <= 1'b1;
            settled_run_r <= run_r;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          // Hold until the result register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_conv_r     <= settled_r;
            out_chk_r      <= checked_r;
            out_conv_run_r <= settled_r ? settled_run_r : '0;
            out_block_r    <= blocker_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_converged        = out_conv_r;
  assign out_check_done       = out_chk_r;
  assign out_converged_at_run = out_conv_run_r;
  assign out_blocking_run     = out_block_r;

endmodule
`default_nettype wire

@@ rtl/core/wsd_checker.sv @@
// Port-level assertions for the window settling detector, bound to the top level.
`default_nettype none
module wsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_converged,
  input wire logic        out_check_done,
  input wire logic [15:0] out_converged_at_run,
  input wire logic [15:0] out_blocking_run
);

  logic seen_conv_r;

  // Remember that a settled result has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_conv_r <= 1'b0;
    end else if (out_valid && out_ready && out_converged) begin
      seen_conv_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_converged)
      && $stable(out_check_done) && $stable(out_converged_at_run)
      && $stable(out_blocking_run))
    else $error("result item changed while stalled");

  a_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_converged |-> out_converged_at_run == 16'd0)
    else $error("convergence run reported while not converged");

  a_run_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged && out_check_done |-> out_converged_at_run != 16'd0)
    else $error("convergence found with zero run count");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_conv_r |-> out_converged && !out_check_done)
    else $error("convergence flag dropped or check ran after settling");

endmodule

bind window_settling_detector wsd_checker u_wsd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_converged        (out_converged),
  .out_check_done       (out_check_done),
  .out_converged_at_run (out_converged_at_run),
  .out_blocking_run     (out_blocking_run)
);
`default_nettype wire

@@ tb/window_settling_detector_tb.sv @@
// Self-checking testbench for the window settling detector.
`timescale 1ns / 1ps
module window_settling_detector_tb;
  import wsd_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLE_MAX   = 24'hFFFFFF;
  localparam int ITEMS_PER_SETTING = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 140;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PRINT_CAP    = 40;

  // what the detector reports for one item
  typedef struct packed {
    logic                converged;
    logic                check_done;
    logic [RUN_BITS-1:0] converged_at;
    logic [RUN_BITS-1:0] blocking_run;
  } settle_result_t;

  // mirror of the detector's run state and settings
  typedef struct packed {
    logic [WINDOW_DEPTH-1:0][SAMPLE_PORT_BITS-1:0] ring;
    logic [5:0]            wr_ptr;
    logic [RUN_BITS-1:0]   runs;
    logic [RUN_BITS-1:0]   blocker;
    logic                  settled;
    logic [RUN_BITS-1:0]   settled_at;
    logic [LEN_BITS-1:0]   len;
    logic [LIMIT_BITS-1:0] lim;
  } detector_state_t;

  typedef enum logic [1:0] {
    STEP_SAMPLE,
    STEP_SET_LEN,
    STEP_SET_LIM
  } step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_DATA_BITS-1:0] value;
    logic                   typed;
    settle_result_t         want;
  } dir_step_t;

  localparam settle_result_t NO_RESULT = '0;
  localparam int CLOSE_FIRST = 16;
  localparam int STEP_COUNT  = 24;

  // Opening rows probe the extremes before any settling can happen; the
  // closing rows widen the limit and force the window to settle, then show
  // that settled items no longer check.
  dir_step_t dir_steps [0:STEP_COUNT-1] = '{
    // fewer samples than the reset window length: nothing to check yet
    '{STEP_SAMPLE,  24'h000000, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0}},
    '{STEP_SAMPLE,  24'hFFFFFF, 1'b1, '{1'b0, 1'b0, 16'd0, 16'd0}},
    // shortest real window, zero tolerance, full-scale swings
    '{STEP_SET_LEN, 24'd2,      1'b0, NO_RESULT},
    '{STEP_SET_LIM, 24'd0,      1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h000000, 1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h800000, 1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h7FFFFF, 1'b0, NO_RESULT},
    // small window with a tight limit just under the spread
    '{STEP_SET_LEN, 24'd3,      1'b0, NO_RESULT},
    '{STEP_SET_LIM, 24'd9,      1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'd100,    1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'd110,    1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'd120,    1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'd300,    1'b0, NO_RESULT},
    // oversize length clamps to the full window
    '{STEP_SET_LEN, 24'd127,    1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h555555, 1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'hAAAAAA, 1'b0, NO_RESULT},
    // closing: widest limit, single-sample window settles at once
    '{STEP_SET_LIM, 24'hFFFFFF, 1'b0, NO_RESULT},
    '{STEP_SET_LEN, 24'd1,      1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h123456, 1'b0, NO_RESULT},
    // zero length counts as one; settled items are stored but not checked
    '{STEP_SET_LEN, 24'd0,      1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h000000, 1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'hFFFFFF, 1'b0, NO_RESULT},
    '{STEP_SET_LEN, 24'd64,     1'b0, NO_RESULT},
    '{STEP_SAMPLE,  24'h000001, 1'b0, NO_RESULT}
  };

  // window lengths per random setting; zero picks one at random
  int len_plan [0:8] = '{127, 2, 0, 64, 65, 0, 8, 0, 33};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_PORT_BITS-1:0] in_entropy_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_converged;
  logic out_check_done;
  logic [RUN_BITS-1:0] out_converged_at_run;
  logic [RUN_BITS-1:0] out_blocking_run;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  detector_state_t det;
  settle_result_t  expected_results [$];
  settle_result_t  oldest_expected;
  int unsigned     error_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     cycle_count = 0;
  int unsigned     send_idle_pct = 28;
  int unsigned     recv_idle_pct = 54;
  bit              hold_req = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     cluster_base = 0;
  int unsigned     cluster_spread = 0;
  int              phase, sub, plan;

  window_settling_detector i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_entropy_sample    (in_entropy_sample),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_converged        (out_converged),
    .out_check_done       (out_check_done),
    .out_converged_at_run (out_converged_at_run),
    .out_blocking_run     (out_blocking_run),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the mirror by one sample: store it, count the run, and run the
  // window test when the detector is unsettled, has enough samples and the
  // last blocker has slid out of the window.
  function automatic void advance_detector(input detector_state_t cur,
                                           input logic [SAMPLE_PORT_BITS-1:0] smp,
                                           output detector_state_t nxt,
                                           output settle_result_t res);
    int unsigned n, first, k;
    longint unsigned total, bound, scaled, gap;
    logic hit;
    nxt = cur;
    res = '0;
    if (cur.len == '0) n = 1;
    else if (cur.len > WINDOW_DEPTH) n = WINDOW_DEPTH;
    else n = cur.len;
    nxt.ring[nxt.wr_ptr] = smp;
    nxt.wr_ptr = nxt.wr_ptr + 6'd1;
    if (nxt.runs != RUN_MAX) nxt.runs = nxt.runs + 16'd1;
    if (!nxt.settled && nxt.runs >= n && nxt.blocker <= nxt.runs - n) begin
      res.check_done = 1'b1;
      first = (nxt.wr_ptr + WINDOW_DEPTH - n) % WINDOW_DEPTH;
      total = 0;
      for (k = 0; k < n; k++) total += nxt.ring[(first + k) % WINDOW_DEPTH];
      bound = longint'(n) * nxt.lim;
      hit = 1'b0;
      // scan oldest to newest; the first sample off the mean blocks
      for (k = 0; k < n && !hit; k++) begin
        scaled = longint'(n) * nxt.ring[(first + k) % WINDOW_DEPTH];
        gap = (scaled > total) ? scaled - total : total - scaled;
        if (gap > bound) begin
          nxt.blocker = RUN_BITS'(nxt.runs - n + k);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        nxt.settled = 1'b1;
        nxt.settled_at = nxt.runs;
      end
    end
    res.converged = nxt.settled;
    res.converged_at = nxt.settled ? nxt.settled_at : '0;
    res.blocking_run = nxt.blocker;
  endfunction

  // Keep the detector from settling early: if this sample would settle the
  // window, swap in a full-scale outlier instead (one end always fails).
  function automatic logic [SAMPLE_PORT_BITS-1:0] avoid_settling(
      input logic [SAMPLE_PORT_BITS-1:0] smp);
    detector_state_t trial;
    settle_result_t  res;
    advance_detector(det, smp, trial, res);
    if (!res.converged) return smp;
    advance_detector(det, '0, trial, res);
    if (!res.converged) return '0;
    return '1;
  endfunction

  // Mostly samples clustered around a base with a spread near the limit,
  // plus single-bit outliers and raw noise.
  function automatic logic [SAMPLE_PORT_BITS-1:0] shaped_sample();
    int unsigned pick;
    int value;
    pick = $urandom_range(99, 0);
    if (pick < 5) cluster_base = $urandom_range(SAMPLE_MAX, 0);
    if (pick < 10) cluster_spread = $urandom_range(2 * det.lim + 2, 0);
    if (pick < 82) begin
      value = int'(cluster_base) + int'($urandom_range(cluster_spread, 0))
              - int'(cluster_spread / 2);
      if (value < 0) value = 0;
      else if (value > SAMPLE_MAX) value = SAMPLE_MAX;
    end else if (pick < 91) begin
      value = int'(cluster_base ^ (32'd1 << $urandom_range(23, 0)));
    end else begin
      value = int'($urandom_range(SAMPLE_MAX, 0));
    end
    return value[SAMPLE_PORT_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write one register while the detector is idle, and mirror it.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input int unsigned value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW_LEN) det.len = LEN_BITS'(value);
    else det.lim = LIMIT_BITS'(value);
    @(posedge clk);
  endtask

  // Offer one item, wait for the handshake, then queue what it should yield.
  // Valid stays high on return so the next item can follow back to back.
  task automatic send_sample(input logic [SAMPLE_PORT_BITS-1:0] smp,
                             input logic typed, input settle_result_t want);
    detector_state_t nxt;
    settle_result_t  res;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_entropy_sample <= smp;
    do @(negedge clk); while (in_ready !== 1'b1);
    @(posedge clk);
    advance_detector(det, smp, nxt, res);
    det = nxt;
    expected_results.push_back(typed ? want : res);
  endtask

  task automatic run_steps(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      case (dir_steps[i].kind)
        STEP_SET_LEN: write_register(CFG_WINDOW_LEN, dir_steps[i].value);
        STEP_SET_LIM: write_register(CFG_DEV_LIMIT, dir_steps[i].value);
        default: begin
          // opening rows must not settle; closing rows are meant to
          if (i < CLOSE_FIRST)
            send_sample(avoid_settling(dir_steps[i].value), dir_steps[i].typed,
                        dir_steps[i].want);
          else
            send_sample(dir_steps[i].value, dir_steps[i].typed, dir_steps[i].want);
        end
      endcase
    end
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Compare at the falling edge; valid and ready are settled by then and the
  // handshake completes at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested item", 32'd1, 32'd0);
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_converged !== oldest_expected.converged)
          report_mismatch("converged", out_converged, oldest_expected.converged);
        if (out_check_done !== oldest_expected.check_done)
          report_mismatch("check_done", out_check_done, oldest_expected.check_done);
        if (out_converged_at_run !== oldest_expected.converged_at)
          report_mismatch("converged_at_run", out_converged_at_run,
                          oldest_expected.converged_at);
        if (out_blocking_run !== oldest_expected.blocking_run)
          report_mismatch("blocking_run", out_blocking_run, oldest_expected.blocking_run);
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("window_settling_detector: mismatch");
    $finish;
  end

  initial begin
    det = '0;
    det.len = LEN_BITS'(25);
    det.lim = LIMIT_BITS'(655);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_steps(0, CLOSE_FIRST - 1);

    // Random part: receiver-heavy idling, then sender-heavy, then none.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 28 : 0;
      for (sub = 0; sub < 3; sub++) begin
        plan = len_plan[phase * 3 + sub];
        if (plan == 0) plan = $urandom_range(127, 2);
        write_register(CFG_WINDOW_LEN, plan);
        write_register(CFG_DEV_LIMIT, (phase == 0 && sub == 0) ? 0 :
                       $urandom_range(32'd1 << $urandom_range(20, 4), 0));
        cluster_base = $urandom_range(SAMPLE_MAX, 0);
        cluster_spread = det.lim;
        // stall the result side while items keep coming, so the input backs up
        if (phase == 2 && sub == 0) hold_req = 1'b1;
        repeat (ITEMS_PER_SETTING) send_sample(avoid_settling(shaped_sample()), 1'b0, '0);
      end
    end

    run_steps(CLOSE_FIRST, STEP_COUNT - 1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0)
      $display("window_settling_detector: match");
    else
      $display("window_settling_detector: mismatch");
    $finish;
  end

endmodule
